// ----- rtl/core/doubly_linked_list_engine_assert.svh -----
// assertion macros shared by the checker
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define DLLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dlle_pkg.sv -----
package dlle_pkg;

  localparam int VALUE_WIDTH = 32;

  localparam logic [4:0] OP_CLEAR      = 5'd0;
  localparam logic [4:0] OP_INS_HEAD   = 5'd1;
  localparam logic [4:0] OP_INS_TAIL   = 5'd2;
  localparam logic [4:0] OP_CUR_FIRST  = 5'd3;
  localparam logic [4:0] OP_CUR_LAST   = 5'd4;
  localparam logic [4:0] OP_RD_HEAD    = 5'd5;
  localparam logic [4:0] OP_RD_TAIL    = 5'd6;
  localparam logic [4:0] OP_DEL_HEAD   = 5'd7;
  localparam logic [4:0] OP_DEL_TAIL   = 5'd8;
  localparam logic [4:0] OP_DEL_AFTER  = 5'd9;
  localparam logic [4:0] OP_DEL_BEFORE = 5'd10;
  localparam logic [4:0] OP_INS_AFTER  = 5'd11;
  localparam logic [4:0] OP_INS_BEFORE = 5'd12;
  localparam logic [4:0] OP_RD_CUR     = 5'd13;
  localparam logic [4:0] OP_WR_CUR     = 5'd14;
  localparam logic [4:0] OP_CUR_NEXT   = 5'd15;
  localparam logic [4:0] OP_CUR_PREV   = 5'd16;
  localparam logic [4:0] OP_QUERY      = 5'd17;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [4:0]                   operation;
    logic signed [VALUE_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic [1:0]                   status;
    logic                         cursor_valid;
    logic [8:0]                   node_count;
  } rsp_t;

endpackage

// ----- rtl/core/dlle_ram.sv -----
module dlle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/doubly_linked_list_engine.sv -----
// response time is set by the number of node memory accesses that the command makes;
// a stalled response adds its wait
// one command in flight at a time
// node value, next and prev memories each have one read and one write port
// reset: list, cursor and free list empty; node memories are not cleared
module doubly_linked_list_engine #(
  parameter int POOL_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dlle_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dlle_pkg::rsp_t rsp
);
  import dlle_pkg::*;

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ISSUE1   = 4'd1;
  localparam logic [3:0] S_EVAL1    = 4'd2;
  localparam logic [3:0] S_ISSUE2   = 4'd3;
  localparam logic [3:0] S_EVAL2    = 4'd4;
  localparam logic [3:0] S_UNLINK1  = 4'd5;
  localparam logic [3:0] S_UNLINK2  = 4'd6;
  localparam logic [3:0] S_ALLOC    = 4'd7;
  localparam logic [3:0] S_ALLOC_RD = 4'd8;
  localparam logic [3:0] S_LINK1    = 4'd9;
  localparam logic [3:0] S_LINK2    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]             state;
  logic [4:0]             op;
  logic [VALUE_WIDTH-1:0] val;
  logic [PW-1:0]          head, tail, cur, free_head, fresh, used;
  logic [PW-1:0]          n, a, b;
  logic [31:0]            rv;
  logic [1:0]             st;

  logic [PW-1:0]          ra1, raddr;
  logic                   nx_we, pv_we, val_we;
  logic [PW-1:0]          nx_waddr, pv_waddr, val_waddr;
  logic [PW-1:0]          nx_wdata, pv_wdata;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [PW-1:0]          nx_rd, pv_rd;
  logic [VALUE_WIDTH-1:0] val_rd;

  logic [VALUE_WIDTH+31:0] cmd_ext, rd_ext;
  logic [PW+8:0]           cnt_ext;

  assign cmd_ext = {{VALUE_WIDTH{1'b0}}, cmd.value};
  assign rd_ext  = {32'd0, val_rd};
  assign cnt_ext = {9'd0, used};

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    case (op)
      OP_RD_HEAD, OP_DEL_HEAD: ra1 = head;
      OP_RD_TAIL, OP_DEL_TAIL: ra1 = tail;
      default:                 ra1 = cur;
    endcase
  end

  always_comb begin
    case (state)
      S_ISSUE1: raddr = ra1;
      S_ALLOC:  raddr = free_head;
      default:  raddr = n;
    endcase
  end

  // memory writes per step
  always_comb begin
    nx_we     = 1'b0;
    pv_we     = 1'b0;
    val_we    = 1'b0;
    nx_waddr  = n;
    pv_waddr  = n;
    val_waddr = n;
    nx_wdata  = b;
    pv_wdata  = a;
    val_wdata = val;
    case (state)
      S_EVAL1: begin
        if (op == OP_CLEAR && head != NIL) begin
          nx_we    = 1'b1;
          nx_waddr = tail;
          nx_wdata = free_head;
        end
        if (op == OP_WR_CUR && cur != NIL) begin
          val_we    = 1'b1;
          val_waddr = cur;
        end
      end
      S_UNLINK1: begin
        nx_we    = (a != NIL);
        nx_waddr = a;
        nx_wdata = b;
        pv_we    = (b != NIL);
        pv_waddr = b;
        pv_wdata = a;
      end
      S_UNLINK2: begin
        nx_we    = 1'b1;
        nx_wdata = free_head;
      end
      S_LINK1: begin
        nx_we  = 1'b1;
        pv_we  = 1'b1;
        val_we = 1'b1;
      end
      S_LINK2: begin
        nx_we    = (a != NIL);
        nx_waddr = a;
        nx_wdata = n;
        pv_we    = (b != NIL);
        pv_waddr = b;
        pv_wdata = n;
      end
      default: ;
    endcase
  end

  dlle_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr[AW-1:0]), .wdata(nx_wdata),
    .raddr(raddr[AW-1:0]), .rdata(nx_rd)
  );

  dlle_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr[AW-1:0]), .wdata(pv_wdata),
    .raddr(raddr[AW-1:0]), .rdata(pv_rd)
  );

  dlle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_value (
    .clk(clk), .we(val_we), .waddr(val_waddr[AW-1:0]), .wdata(val_wdata),
    .raddr(raddr[AW-1:0]), .rdata(val_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cur       <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      used      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op    <= cmd.operation;
            val   <= cmd_ext[VALUE_WIDTH-1:0];
            rv    <= '0;
            st    <= ST_OK;
            state <= S_ISSUE1;
          end
        end
        S_ISSUE1: begin
          n     <= ra1;
          state <= S_EVAL1;
        end
        S_EVAL1: begin
          case (op)
            OP_CLEAR: begin
              if (head != NIL) begin
                free_head <= head;
              end
              head  <= NIL;
              tail  <= NIL;
              cur   <= NIL;
              used  <= '0;
              state <= S_DONE;
            end
            OP_INS_HEAD: begin
              a     <= NIL;
              b     <= head;
              state <= S_ALLOC;
            end
            OP_INS_TAIL: begin
              a     <= tail;
              b     <= NIL;
              state <= S_ALLOC;
            end
            OP_CUR_FIRST: begin
              cur   <= head;
              state <= S_DONE;
            end
            OP_CUR_LAST: begin
              cur   <= tail;
              state <= S_DONE;
            end
            OP_RD_HEAD, OP_RD_TAIL, OP_RD_CUR: begin
              if (n != NIL) begin
                rv <= rd_ext[31:0];
              end else begin
                st <= ST_EMPTY;
              end
              state <= S_DONE;
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
              if (n != NIL) begin
                a     <= pv_rd;
                b     <= nx_rd;
                state <= S_UNLINK1;
              end else begin
                state <= S_DONE;
              end
            end
            OP_DEL_AFTER: begin
              if (cur != NIL && nx_rd != NIL) begin
                n     <= nx_rd;
                state <= S_ISSUE2;
              end else begin
                state <= S_DONE;
              end
            end
            OP_DEL_BEFORE: begin
              if (cur != NIL && pv_rd != NIL) begin
                n     <= pv_rd;
                state <= S_ISSUE2;
              end else begin
                state <= S_DONE;
              end
            end
            OP_INS_AFTER: begin
              if (cur != NIL) begin
                a     <= cur;
                b     <= nx_rd;
                state <= S_ALLOC;
              end else begin
                state <= S_DONE;
              end
            end
            OP_INS_BEFORE: begin
              if (cur != NIL) begin
                a     <= pv_rd;
                b     <= cur;
                state <= S_ALLOC;
              end else begin
                state <= S_DONE;
              end
            end
            OP_CUR_NEXT: begin
              if (cur != NIL) cur <= nx_rd;
              state <= S_DONE;
            end
            OP_CUR_PREV: begin
              if (cur != NIL) cur <= pv_rd;
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_ISSUE2: state <= S_EVAL2;
        S_EVAL2: begin
          a     <= pv_rd;
          b     <= nx_rd;
          state <= S_UNLINK1;
        end
        S_UNLINK1: begin
          if (a == NIL) head <= b;
          if (b == NIL) tail <= a;
          if (cur == n) cur <= NIL;
          state <= S_UNLINK2;
        end
        S_UNLINK2: begin
          free_head <= n;
          if (used != '0) used <= used - PW'(1);
          state <= S_DONE;
        end
        S_ALLOC: begin
          if (free_head != NIL) begin
            n     <= free_head;
            state <= S_ALLOC_RD;
          end else if (fresh != NIL) begin
            n     <= fresh;
            fresh <= fresh + PW'(1);
            used  <= used + PW'(1);
            state <= S_LINK1;
          end else begin
            st    <= ST_FULL;
            state <= S_DONE;
          end
        end
        S_ALLOC_RD: begin
          // free list pop: successor of the taken node
          free_head <= nx_rd;
          used      <= used + PW'(1);
          state     <= S_LINK1;
        end
        S_LINK1: state <= S_LINK2;
        S_LINK2: begin
          if (a == NIL) head <= n;
          if (b == NIL) tail <= n;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
      rsp.read_value   <= rv;
      rsp.status       <= st;
      rsp.cursor_valid <= (cur != NIL);
      rsp.node_count   <= cnt_ext[8:0];
    end
  end

endmodule

// ----- rtl/core/dlle_checker.sv -----
`include "doubly_linked_list_engine_assert.svh"

module dlle_checker #(
  parameter int POOL_DEPTH = 256
) (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input dlle_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input dlle_pkg::rsp_t rsp
);
  import dlle_pkg::*;

  // a stalled response beat holds
  `DLLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp dropped")

  // one command in flight
  `DLLE_ASSERT_NEXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready, "cmd accepted twice")

  `DLLE_ASSERT_NOW(a_status, rsp_valid, rsp.status <= ST_FULL, "bad status")

  // failed commands return no data
  `DLLE_ASSERT_NOW(a_fail_zero, rsp_valid && rsp.status != ST_OK, rsp.read_value == 0, "data on failure")

  `DLLE_ASSERT_NOW(a_count, rsp_valid, 32'(rsp.node_count) <= 32'(POOL_DEPTH), "count over pool")

endmodule

bind doubly_linked_list_engine dlle_checker #(.POOL_DEPTH(POOL_DEPTH)) u_dlle_checker (.*);
